>>> src/uer_pkg.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Shared types, widths, register indexes and reset values for the ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

    localparam int DIV_W      = 16;   // tick divisor width
    localparam int MAXD_W     = 8;    // distance limit and distance width
    localparam int TOUT_W     = 10;   // timeout overflow count width
    localparam int TICK_W     = 19;   // elapsed tick counter width
    localparam int OVF_SHIFT  = 8;    // one overflow is 256 ticks
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [DIV_W-1:0]  TICK_DIVISOR_RST = 16'd466;
    localparam logic [MAXD_W-1:0] MAX_DISTANCE_RST = 8'd20;
    localparam logic [TOUT_W-1:0] TIMEOUT_OVF_RST  = 10'd730;

    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_TRIGGER = 2'd1,
        FUNC_ECHO    = 2'd2,
        FUNC_UNUSED  = 2'd3
    } uer_func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_DIVISOR = 2'd0,
        CFG_MAX_DISTANCE = 2'd1,
        CFG_TIMEOUT_OVF  = 2'd2,
        CFG_NONE         = 2'd3
    } uer_cfg_idx_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic div_start;
        logic commit;
    } uer_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } uer_sts_t;

endpackage

>>> src/uer_divider.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger divider
// Restoring divider, one quotient bit per cycle, for elapsed ticks by divisor.
// ----------------------------------------------------------------------------
module uer_divider
    import uer_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TICK_W-1:0] dividend,
    input  logic [DIV_W-1:0]  divisor,
    output logic              done,
    output logic [TICK_W-1:0] quotient
);

    localparam int CNT_W = $clog2(TICK_W + 1);

    logic [TICK_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  dsr_reg, dsr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[TICK_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            // A zero divisor behaves as one.
            dsr_next  = (divisor == '0) ? DIV_W'(1) : divisor;
            cnt_next  = CNT_W'(TICK_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = DIV_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
            end
            quo_next = {quo_reg[TICK_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> src/uer_datapath.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger datapath
// Configuration registers, ranging state, divider and the output register.
// ----------------------------------------------------------------------------
module uer_datapath
    import uer_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  uer_cmd_t              cmd,
    output uer_sts_t              sts,
    input  logic [1:0]            func,
    input  logic                  going_back,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  trigger_pulse,
    output logic                  detected,
    output logic [MAXD_W-1:0]     distance,
    output logic                  reversing_alert,
    output logic                  timed_out
);

    logic [DIV_W-1:0]  tdiv_reg;
    logic [MAXD_W-1:0] maxd_reg;
    logic [TOUT_W-1:0] tout_reg;

    logic              armed_reg, armed_next;
    logic              echo_reg, echo_next;
    logic [TICK_W-1:0] elapsed_reg, elapsed_next;
    logic              reverse_reg, reverse_next;

    uer_func_t         func_reg;
    logic              back_reg;

    logic              oval_reg;
    logic              pulse_reg, pulse_next;
    logic              det_reg, det_next;
    logic [MAXD_W-1:0] dist_reg, dist_next;
    logic              alert_reg, alert_next;
    logic              tout_flag_reg, tout_flag_next;

    logic [TOUT_W:0]   ovf_plus;
    logic [TICK_W-1:0] limit;
    logic [TICK_W-1:0] tick_inc;
    logic              div_done;
    logic [TICK_W-1:0] quotient;
    logic              in_range;

    uer_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (elapsed_reg),
        .divisor  (tdiv_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign ovf_plus = {1'b0, tout_reg} + (TOUT_W+1)'(1);
    assign limit    = TICK_W'({ovf_plus, {OVF_SHIFT{1'b0}}});
    assign tick_inc = elapsed_reg + TICK_W'(1);
    assign in_range = (quotient != '0) && (quotient < TICK_W'(maxd_reg));

    assign sts.need_div = (func_reg == FUNC_ECHO) && armed_reg && echo_reg;
    assign sts.div_done = div_done;
    assign sts.out_free = !oval_reg || out_ready;

    // Effect of the held item on the ranging state and its result word.
    always_comb
    begin
        armed_next     = armed_reg;
        echo_next      = echo_reg;
        elapsed_next   = elapsed_reg;
        reverse_next   = reverse_reg;
        pulse_next     = 1'b0;
        det_next       = 1'b0;
        dist_next      = '0;
        alert_next     = 1'b0;
        tout_flag_next = 1'b0;
        case (func_reg)
            FUNC_TICK:
            begin
                if (tick_inc >= limit)
                begin
                    elapsed_next   = '0;
                    armed_next     = 1'b0;
                    echo_next      = 1'b0;
                    tout_flag_next = 1'b1;
                end
                else
                begin
                    elapsed_next = tick_inc;
                end
            end
            FUNC_TRIGGER:
            begin
                reverse_next = back_reg;
                if (!armed_reg)
                begin
                    pulse_next = 1'b1;
                    armed_next = 1'b1;
                end
            end
            FUNC_ECHO:
            begin
                if (armed_reg)
                begin
                    if (!echo_reg)
                    begin
                        elapsed_next = '0;
                        echo_next    = 1'b1;
                    end
                    else if (in_range)
                    begin
                        det_next     = 1'b1;
                        dist_next    = quotient[MAXD_W-1:0];
                        alert_next   = reverse_reg;
                        elapsed_next = '0;
                        echo_next    = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tdiv_reg    <= TICK_DIVISOR_RST;
            maxd_reg    <= MAX_DISTANCE_RST;
            tout_reg    <= TIMEOUT_OVF_RST;
            armed_reg   <= 1'b0;
            echo_reg    <= 1'b0;
            elapsed_reg <= '0;
            reverse_reg <= 1'b0;
            oval_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (uer_cfg_idx_t'(cfg_index))
                    CFG_TICK_DIVISOR: tdiv_reg <= cfg_data[DIV_W-1:0];
                    CFG_MAX_DISTANCE: maxd_reg <= cfg_data[MAXD_W-1:0];
                    CFG_TIMEOUT_OVF:  tout_reg <= cfg_data[TOUT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.commit)
            begin
                armed_reg   <= armed_next;
                echo_reg    <= echo_next;
                elapsed_reg <= elapsed_next;
                reverse_reg <= reverse_next;
                oval_reg    <= 1'b1;
            end
            else if (out_ready)
            begin
                oval_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg <= uer_func_t'(func);
            back_reg <= going_back;
        end
        if (cmd.commit)
        begin
            pulse_reg     <= pulse_next;
            det_reg       <= det_next;
            dist_reg      <= dist_next;
            alert_reg     <= alert_next;
            tout_flag_reg <= tout_flag_next;
        end
    end

    assign out_valid       = oval_reg;
    assign trigger_pulse   = pulse_reg;
    assign detected        = det_reg;
    assign distance        = dist_reg;
    assign reversing_alert = alert_reg;
    assign timed_out       = tout_flag_reg;

endmodule

>>> src/uer_ctrl.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger controller
// Sequences one input word through decode, division where needed and commit.
// ----------------------------------------------------------------------------
module uer_ctrl
    import uer_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  uer_sts_t sts,
    output uer_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIVIDE,
        ST_COMMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.load_item = 1'b0;
        cmd.div_start = 1'b0;
        cmd.commit    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                // Only a second echo change while armed needs a distance.
                if (sts.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
                else
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_DIVIDE:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger
// Trigger, echo timing, distance and timeout sequencer for an ultrasonic sensor.
//
//   Channel  Handshake             Word
//   in       in_valid / in_ready   func, going_back
//   out      out_valid / out_ready trigger_pulse, detected, distance,
//                                  reversing_alert, timed_out
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// Tick, trigger and first echo change words pass the decide and commit states;
// a measuring echo change also passes the divide state, one quotient bit per
// cycle over the 19-bit tick count. One input word is in work at a time. The
// output register holds a result while out_ready is low and the next input word
// may be accepted meanwhile. Reset restores control, ranging and config state.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger
    import uer_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            func,
    input  logic                  going_back,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  trigger_pulse,
    output logic                  detected,
    output logic [MAXD_W-1:0]     distance,
    output logic                  reversing_alert,
    output logic                  timed_out,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    uer_cmd_t cmd;
    uer_sts_t sts;

    assign cfg_ready = 1'b1;

    uer_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    uer_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .func            (func),
        .going_back      (going_back),
        .cfg_we          (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .trigger_pulse   (trigger_pulse),
        .detected        (detected),
        .distance        (distance),
        .reversing_alert (reversing_alert),
        .timed_out       (timed_out)
    );

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger testbench
// Drives tick, trigger and echo words into the ranger and checks each result
// word against a cycle-free model of the ranging sequence kept in step here.
// A short directed run covers the corner cases, then random ranging cycles,
// timeouts and noise run under several register settings.
// ----------------------------------------------------------------------------
module testbench
    import uer_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic              trigger_pulse;
        logic              detected;
        logic [MAXD_W-1:0] distance;
        logic              reversing_alert;
        logic              timed_out;
    } reading_t;

    typedef enum int {SINK_ALWAYS, SINK_RANDOM, SINK_SLOW} sink_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [1:0]            func = FUNC_TICK;
    logic                  going_back = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  trigger_pulse;
    logic                  detected;
    logic [MAXD_W-1:0]     distance;
    logic                  reversing_alert;
    logic                  timed_out;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_NONE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow of the ranger's registers and state.
    logic [DIV_W-1:0]  div_setting     = TICK_DIVISOR_RST;
    logic [MAXD_W-1:0] range_limit     = MAX_DISTANCE_RST;
    logic [TOUT_W-1:0] timeout_setting = TIMEOUT_OVF_RST;
    logic              armed_now    = 1'b0;
    logic              echo_running = 1'b0;
    logic [TICK_W-1:0] tick_count   = '0;
    logic              reversing    = 1'b0;

    reading_t expected_readings[$];
    int       mismatches = 0;
    int       words_sent = 0;
    int       burst_left = 0;
    int       quiet_cycles = 0;

    sink_mode_t sink_mode = SINK_ALWAYS;
    int         sink_left = 0;
    int         sink_phase = 0;

    ultrasonic_echo_ranger i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .going_back      (going_back),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .trigger_pulse   (trigger_pulse),
        .detected        (detected),
        .distance        (distance),
        .reversing_alert (reversing_alert),
        .timed_out       (timed_out),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic reading_t predict_reading(input uer_func_t f, input logic back);
        reading_t    r;
        int unsigned limit;
        int unsigned divisor;
        int unsigned q;
        r = '0;
        case (f)
            FUNC_TICK:
            begin
                limit = (timeout_setting + 1) * 256;
                tick_count = tick_count + 1'b1;
                if (tick_count >= limit)
                begin
                    tick_count = '0;
                    armed_now = 1'b0;
                    echo_running = 1'b0;
                    r.timed_out = 1'b1;
                end
            end
            FUNC_TRIGGER:
            begin
                reversing = back;
                if (!armed_now)
                begin
                    r.trigger_pulse = 1'b1;
                    armed_now = 1'b1;
                end
            end
            FUNC_ECHO:
            begin
                if (armed_now && !echo_running)
                begin
                    tick_count = '0;
                    echo_running = 1'b1;
                end
                else if (armed_now)
                begin
                    divisor = (div_setting == 0) ? 1 : div_setting;
                    q = tick_count / divisor;
                    if (q > 0 && q < range_limit)
                    begin
                        r.detected = 1'b1;
                        r.distance = q[MAXD_W-1:0];
                        r.reversing_alert = reversing;
                        tick_count = '0;
                        echo_running = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] want_v,
                                   input logic [7:0] got_v);
        mismatches++;
        $display("%0t ns: %s: expected %0h, got %0h", $time, what, want_v, got_v);
    endtask

    // Sender: bursts of words with random gaps; valid stays up through a burst.
    task automatic send_word(input uer_func_t f, input logic back);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        func       <= f;
        going_back <= back;
        do
            @(posedge clk);
        while (!in_ready);
        expected_readings.push_back(predict_reading(f, back));
        words_sent++;
    endtask

    task automatic send_random_word();
        send_word(uer_func_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    endtask

    task automatic finish_stream();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input uer_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_TICK_DIVISOR: div_setting = data[DIV_W-1:0];
            CFG_MAX_DISTANCE: range_limit = data[MAXD_W-1:0];
            CFG_TIMEOUT_OVF:  timeout_setting = data[TOUT_W-1:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Unused upper data bits are filled at random; the ranger must drop them.
    task automatic set_ranging(input logic [DIV_W-1:0] div, input logic [MAXD_W-1:0] maxd,
                               input logic [TOUT_W-1:0] tout);
        logic [CFG_DATA_W-1:0] word;
        finish_stream();
        write_reg(CFG_TICK_DIVISOR, div);
        word = CFG_DATA_W'($urandom);
        word[MAXD_W-1:0] = maxd;
        write_reg(CFG_MAX_DISTANCE, word);
        word = CFG_DATA_W'($urandom);
        word[TOUT_W-1:0] = tout;
        write_reg(CFG_TIMEOUT_OVF, word);
    endtask

    task automatic test_special_cases();
        set_ranging(16'd0, 8'd3, 10'd1);
        write_reg(CFG_NONE, 16'hFFFF);
        send_word(FUNC_UNUSED, 1'b1);
        send_word(FUNC_ECHO, 1'b0);      // ignored while idle
        send_word(FUNC_TICK, 1'b1);
        send_word(FUNC_TRIGGER, 1'b1);
        send_word(FUNC_TRIGGER, 1'b0);   // already armed: no pulse, flag still taken
        send_word(FUNC_TRIGGER, 1'b1);
        send_word(FUNC_ECHO, 1'b0);
        send_word(FUNC_ECHO, 1'b1);      // zero distance
        send_word(FUNC_TICK, 1'b0);
        send_word(FUNC_ECHO, 1'b0);      // distance 1 with a zero divisor, alert
        send_word(FUNC_TRIGGER, 1'b0);   // still armed after a detection
        send_word(FUNC_UNUSED, 1'b0);
        send_word(FUNC_ECHO, 1'b1);
        send_word(FUNC_TICK, 1'b0);
        send_word(FUNC_TICK, 1'b1);
        send_word(FUNC_ECHO, 1'b0);      // one below the limit, no alert
        send_word(FUNC_ECHO, 1'b0);
        repeat (3) send_word(FUNC_TICK, 1'b0);
        send_word(FUNC_ECHO, 1'b1);      // equal to the limit: out of range
        send_word(FUNC_TICK, 1'b0);
        send_word(FUNC_ECHO, 1'b0);      // measured again from the same start
    endtask

    task automatic test_ranging_cycles(input logic [DIV_W-1:0] div,
                                       input logic [MAXD_W-1:0] maxd,
                                       input logic [TOUT_W-1:0] tout, input int budget);
        int start;
        int pick;
        int units;
        int ticks;
        int need;
        set_ranging(div, maxd, tout);
        start = words_sent;
        while (words_sent - start < budget)
        begin
            pick = $urandom_range(0, 99);
            need = (timeout_setting + 1) * 256 - tick_count;
            if (pick < 12 && need <= 320)
            begin
                // Run the free tick count up to the timeout and up to two ticks beyond.
                repeat (need + $urandom_range(0, 2))
                    send_word(FUNC_TICK, 1'($urandom_range(0, 1)));
            end
            else if (pick < 78)
            begin
                units = ($urandom_range(0, 3) == 0) ? $urandom_range(0, maxd)
                                                    : $urandom_range(0, (maxd < 12) ? maxd : 12);
                ticks = (div <= 64) ? div * units + $urandom_range(0, div - 1)
                                    : $urandom_range(0, 300);
                // Long echoes are drawn again from a bounded range to keep the run short.
                if (ticks > 300)
                    ticks = $urandom_range(0, 300);
                send_word(FUNC_TRIGGER, 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 3) == 0)
                    send_word(FUNC_TICK, 1'($urandom_range(0, 1)));
                send_word(FUNC_ECHO, 1'($urandom_range(0, 1)));
                repeat (ticks) send_word(FUNC_TICK, 1'($urandom_range(0, 1)));
                send_word(FUNC_ECHO, 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 3) == 0)
                begin
                    repeat ((div <= 64) ? $urandom_range(0, 2 * div) : $urandom_range(0, 5))
                        send_word(FUNC_TICK, 1'($urandom_range(0, 1)));
                    send_word(FUNC_ECHO, 1'($urandom_range(0, 1)));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6)) send_random_word();
            end
        end
    endtask

    // Receiver: switches between always ready, random stalls and a slow beat.
    always @(negedge clk)
    begin
        if (sink_left == 0)
        begin
            sink_mode = sink_mode_t'($urandom_range(0, 2));
            sink_left = $urandom_range(20, 200);
        end
        sink_left--;
        sink_phase = (sink_phase + 1) % 5;
        case (sink_mode)
            SINK_ALWAYS: out_ready <= 1'b1;
            SINK_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
            default:     out_ready <= (sink_phase == 0);
        endcase
    end

    always @(posedge clk)
    begin : check_readings
        reading_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_readings.size() == 0)
                report_mismatch("result word with nothing expected", 8'h0, 8'h0);
            else
            begin
                want = expected_readings.pop_front();
                if (trigger_pulse !== want.trigger_pulse)
                    report_mismatch("trigger_pulse", 8'(want.trigger_pulse),
                                    8'(trigger_pulse));
                if (detected !== want.detected)
                    report_mismatch("detected", 8'(want.detected), 8'(detected));
                if (distance !== want.distance)
                    report_mismatch("distance", want.distance, distance);
                if (reversing_alert !== want.reversing_alert)
                    report_mismatch("reversing_alert", 8'(want.reversing_alert),
                                    8'(reversing_alert));
                if (timed_out !== want.timed_out)
                    report_mismatch("timed_out", 8'(want.timed_out), 8'(timed_out));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_special_cases();
        test_ranging_cycles(TICK_DIVISOR_RST, MAX_DISTANCE_RST, TIMEOUT_OVF_RST, 150);
        test_ranging_cycles(16'd1, 8'd255, 10'd1, 300);
        test_ranging_cycles(16'd65535, 8'd1, 10'd1023, 100);
        test_ranging_cycles(16'd3, 8'd10, 10'd2, 300);
        test_ranging_cycles(DIV_W'($urandom_range(1, 8)), MAXD_W'($urandom_range(2, 255)),
                            TOUT_W'($urandom_range(1, 3)), 300);
        test_ranging_cycles(16'd40, 8'd200, 10'd1, 150);
        finish_stream();
        repeat (30) @(posedge clk);
        if (mismatches == 0 && expected_readings.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
